/* sv/lsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lsa_pkg;

  // Default width of the frame count, sign bit excluded
  localparam int COUNT_BITS = 16;

  localparam int PATTERN_W = 3;
  localparam int LEVEL_W   = 7;
  localparam int FRAME_W   = 7;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 2;

  // Animation frame counter wraps after this frame
  localparam logic [FRAME_W-1:0] FRAME_LAST = 7'd119;

  // Item operations
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Pattern codes
  localparam logic [PATTERN_W-1:0] PAT_OFF     = 3'd0;
  localparam logic [PATTERN_W-1:0] PAT_IDLE    = 3'd1;
  localparam logic [PATTERN_W-1:0] PAT_WAITING = 3'd2;
  localparam logic [PATTERN_W-1:0] PAT_FAILURE = 3'd3;
  localparam logic [PATTERN_W-1:0] PAT_SUCCESS = 3'd4;

  // Indicator kinds
  localparam logic [KIND_W-1:0] KIND_RGB  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEDS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;

  // Frame to display, handed from the sequencer to the pattern decoder
  typedef struct packed {
    logic                 valid;
    logic                 ended;
    logic [PATTERN_W-1:0] pattern;
    logic [FRAME_W-1:0]   frame;
  } show_req_t;

  // Decoded indicator levels
  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [3:0]         led;
  } levels_t;

  // Frame index modulo 40, for indexes below 120
  function automatic logic [5:0] mod40(input logic [FRAME_W-1:0] f);
    logic [FRAME_W-1:0] m;
    m = f;
    if (m >= 7'd80) m = m - 7'd80;
    if (m >= 7'd40) m = m - 7'd40;
    return m[5:0];
  endfunction

  // Frame index modulo 12, restoring subtraction
  function automatic logic [3:0] mod12(input logic [FRAME_W-1:0] f);
    logic [FRAME_W-1:0] m;
    m = f;
    if (m >= 7'd96) m = m - 7'd96;
    if (m >= 7'd48) m = m - 7'd48;
    if (m >= 7'd24) m = m - 7'd24;
    if (m >= 7'd12) m = m - 7'd12;
    return m[3:0];
  endfunction

endpackage

`default_nettype wire

/* sv/lsa_show.sv */
`timescale 1ns / 1ps
`default_nettype none

module lsa_show (
  input  wire logic [lsa_pkg::PATTERN_W-1:0] pattern_i,
  input  wire logic [lsa_pkg::FRAME_W-1:0]   frame_i,
  input  wire logic [lsa_pkg::KIND_W-1:0]    kind_i,
  output lsa_pkg::levels_t                   levels_o
);

  logic [5:0]                  m40;
  logic [5:0]                  m20;
  logic [3:0]                  m12;
  logic [3:0]                  wave;
  logic                        blink;
  logic [lsa_pkg::LEVEL_W-1:0] r;
  logic [lsa_pkg::LEVEL_W-1:0] g;
  logic [lsa_pkg::LEVEL_W-1:0] b;
  logic [3:0]                  led;

  // Reduce the frame index for each pattern period
  always_comb begin
    m40 = lsa_pkg::mod40(frame_i);
    m20 = (m40 >= 6'd20) ? (m40 - 6'd20) : m40;
    m12 = lsa_pkg::mod12(frame_i);
  end

  // Decode one frame of the pattern
  always_comb begin
    r     = '0;
    g     = '0;
    b     = '0;
    led   = '0;
    blink = 1'b0;
    wave  = '0;
    case (pattern_i)
      lsa_pkg::PAT_IDLE: begin
        g      = (m40 >= 6'd20) ? {1'b0, m40 - 6'd20} : {1'b0, 6'd20 - m40};
        b      = 7'd20;
        blink  = (m40 < 6'd20);
        led[0] = blink;
        led[3] = ~blink;
      end
      lsa_pkg::PAT_WAITING: begin
        wave   = (m20 >= 6'd10) ? 4'(m20 - 6'd10) : 4'(6'd10 - m20);
        g      = {3'b000, wave};
        r      = ({3'b000, wave} << 3) + ({3'b000, wave} << 1);
        led[0] = (frame_i[1:0] == 2'd0);
        led[1] = (frame_i[1:0] == 2'd1);
        led[2] = (frame_i[1:0] == 2'd3);
        led[3] = (frame_i[1:0] == 2'd2);
      end
      lsa_pkg::PAT_FAILURE: begin
        blink = (m20 < 6'd15);
        r     = blink ? lsa_pkg::LEVEL_FULL : '0;
        led   = {4{blink}};
      end
      lsa_pkg::PAT_SUCCESS: begin
        blink = (m12 < 4'd3);
        g     = blink ? lsa_pkg::LEVEL_FULL : '0;
        led   = {blink, ~blink, ~blink, blink};
      end
      default: begin
        r = '0;
      end
    endcase
  end

  // Route levels to the configured indicator
  always_comb begin
    levels_o = '0;
    case (kind_i)
      lsa_pkg::KIND_RGB: begin
        levels_o.red   = r;
        levels_o.green = g;
        levels_o.blue  = b;
      end
      lsa_pkg::KIND_LEDS: begin
        levels_o.led = led;
      end
      default: begin
        levels_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/lsa_state.sv */
`timescale 1ns / 1ps
`default_nettype none

module lsa_state #(
  parameter int COUNT_BITS = lsa_pkg::COUNT_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            fire_i,
  input  wire logic                            op_i,
  input  wire logic [lsa_pkg::PATTERN_W-1:0]   pattern_i,
  input  wire logic [COUNT_BITS:0]             frames_i,
  input  wire logic                            enable_i,
  input  wire logic                            continuous_i,
  output lsa_pkg::show_req_t                   req_o
);

  logic                          running_q, running_d;
  logic [lsa_pkg::PATTERN_W-1:0] pattern_q, pattern_d;
  logic [COUNT_BITS:0]           frames_q, frames_d;
  logic [lsa_pkg::FRAME_W-1:0]   frame_q, frame_d;

  logic tick;
  logic start;
  logic stop;
  logic fall_back;

  always_comb begin
    tick      = fire_i && (op_i == lsa_pkg::OP_TICK);
    start     = fire_i && (op_i == lsa_pkg::OP_START);
    stop      = (frames_q == '0) || (pattern_q == lsa_pkg::PAT_OFF);
    fall_back = continuous_i && enable_i;
  end

  // Select the frame to show for this tick
  always_comb begin
    req_o.valid = tick && running_q;
    req_o.ended = stop;
    if (stop) begin
      req_o.pattern = fall_back ? lsa_pkg::PAT_IDLE : lsa_pkg::PAT_OFF;
      req_o.frame   = '0;
    end else begin
      req_o.pattern = pattern_q;
      req_o.frame   = frame_q;
    end
  end

  // Advance the run
  always_comb begin
    running_d = running_q;
    pattern_d = pattern_q;
    frames_d  = frames_q;
    frame_d   = frame_q;
    if (start && enable_i) begin
      running_d = 1'b1;
      pattern_d = pattern_i;
      frames_d  = frames_i;
      frame_d   = '0;
    end else if (tick && running_q) begin
      if (stop) begin
        if (fall_back) begin
          pattern_d = lsa_pkg::PAT_IDLE;
          frames_d  = '1;
          frame_d   = {{(lsa_pkg::FRAME_W-1){1'b0}}, 1'b1};
        end else begin
          running_d = 1'b0;
        end
      end else begin
        // endless runs keep their negative count
        if (!frames_q[COUNT_BITS]) begin
          frames_d = frames_q - {{COUNT_BITS{1'b0}}, 1'b1};
        end
        frame_d = (frame_q == lsa_pkg::FRAME_LAST) ? '0 : frame_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b1;
      pattern_q <= lsa_pkg::PAT_OFF;
      frames_q  <= '1;
      frame_q   <= '0;
    end else begin
      running_q <= running_d;
      pattern_q <= pattern_d;
      frames_q  <= frames_d;
      frame_q   <= frame_d;
    end
  end

  a_frame_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q <= lsa_pkg::FRAME_LAST)
    else $error("frame index beyond wrap point");

  a_stop_on_end_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(running_q) |-> $past(tick) && $past(stop))
    else $error("run stopped without an ending tick");

  a_endless_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q[COUNT_BITS] && !start |=> frames_q[COUNT_BITS])
    else $error("endless count turned positive without a start");

endmodule

`default_nettype wire

/* sv/led_status_pattern_animator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Status LED pattern animator.
// Input channel (in_valid_i / in_stall_o): op_i selects a frame tick or a
// pattern start; if enabled, a start loads pattern_i and frames_i (negative: endless).
// Output channel (out_valid_o / out_stall_i): one item per tick of an
// active run, carrying RGB levels or four LED states and run_ended_o.
// Starts and ticks of an inactive run produce no output item.
// An output item is registered, valid the cycle after its tick is accepted.
// Throughput: one input item per cycle; the input is stalled only while a
// held output item is stalled by the receiver.
// Configuration: cfg_we_i writes register cfg_idx_i (0 enable, 1 indicator
// kind, 2 continuous mode) with cfg_data_i.
// Reset: enable 1, RGB kind, continuous mode off, and an active off
// pattern, so the first tick ends the run at once.
// While the receiver stalls a held output item, it holds and no new item is taken.

module led_status_pattern_animator #(
  parameter int COUNT_BITS = lsa_pkg::COUNT_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             op_i,
  input  wire logic [lsa_pkg::PATTERN_W-1:0]    pattern_i,
  input  wire logic signed [COUNT_BITS:0]       frames_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [lsa_pkg::LEVEL_W-1:0]           red_o,
  output logic [lsa_pkg::LEVEL_W-1:0]           green_o,
  output logic [lsa_pkg::LEVEL_W-1:0]           blue_o,
  output logic                                  led_one_o,
  output logic                                  led_two_o,
  output logic                                  led_three_o,
  output logic                                  led_four_o,
  output logic                                  run_ended_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lsa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [lsa_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic                       enable_q;
  logic [lsa_pkg::KIND_W-1:0] kind_q;
  logic                       continuous_q;

  logic               in_fire;
  logic               out_valid_q;
  lsa_pkg::levels_t   levels_q;
  logic               ended_q;
  lsa_pkg::show_req_t req;
  lsa_pkg::levels_t   lvl;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b1;
      kind_q       <= lsa_pkg::KIND_RGB;
      continuous_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsa_pkg::CFG_ENABLE:     enable_q     <= cfg_data_i[0];
        lsa_pkg::CFG_KIND:       kind_q       <= cfg_data_i;
        lsa_pkg::CFG_CONTINUOUS: continuous_q <= cfg_data_i[0];
        default: begin
          enable_q <= enable_q;
        end
      endcase
    end
  end

  // Hold the input while a stalled output item waits
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  lsa_state #(
    .COUNT_BITS(COUNT_BITS)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .op_i        (op_i),
    .pattern_i   (pattern_i),
    .frames_i    (frames_i),
    .enable_i    (enable_q),
    .continuous_i(continuous_q),
    .req_o       (req)
  );

  lsa_show u_show (
    .pattern_i(req.pattern),
    .frame_i  (req.frame),
    .kind_i   (kind_q),
    .levels_o (lvl)
  );

  // Output register: load on a producing tick, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && req.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && req.valid) begin
      levels_q <= lvl;
      ended_q  <= req.ended;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = levels_q.red;
  assign green_o     = levels_q.green;
  assign blue_o      = levels_q.blue;
  assign led_one_o   = levels_q.led[0];
  assign led_two_o   = levels_q.led[1];
  assign led_three_o = levels_q.led[2];
  assign led_four_o  = levels_q.led[3];
  assign run_ended_o = ended_q;

  a_valid_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire) && $past(req.valid))
    else $error("output item without an accepted tick");

  a_kind_gating: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q != lsa_pkg::KIND_RGB) |->
      (lvl.red == '0) && (lvl.green == '0) && (lvl.blue == '0))
    else $error("RGB levels driven for a non-RGB indicator");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (levels_q.red <= lsa_pkg::LEVEL_FULL) &&
      (levels_q.green <= lsa_pkg::LEVEL_FULL) &&
      (levels_q.blue <= lsa_pkg::LEVEL_FULL))
    else $error("brightness above full scale");

endmodule

`default_nettype wire
